[src/spl_pkg.sv]
// Shared types and constants for the stereo peak limiter.
// No dependencies; imported by every module of the limiter.
package spl_pkg;

  // Default sample width and fixed field widths
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int GAIN_W          = 24;
  localparam int COEF_W          = 24;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;

  // Unity gain in Q1.23 and unity coefficient in Q0.24
  localparam logic [GAIN_W-1:0] GAIN_ONE = 24'h800000;
  localparam logic [COEF_W:0]   COEF_ONE = 25'h1000000;

  // Restoring divider: quotient is known to stay below 2^23
  localparam int DIV_STEPS = 23;
  localparam int CNT_W     = 5;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 3'd4;

  // Register reset values
  localparam logic              RST_ENABLE   = 1'b1;
  localparam logic [1:0]        RST_CHANNELS = 2'd2;
  localparam logic [COEF_W-1:0] RST_ATTACK   = 24'd15435777;
  localparam logic [COEF_W-1:0] RST_RELEASE  = 24'd16770227;
  localparam logic [GAIN_W-1:0] RST_CEILING  = 24'd7058133;

  // Multiplier operand selection codes
  typedef logic [2:0] spl_mul_sel_t;
  localparam spl_mul_sel_t MUL_NONE    = 3'd0;
  localparam spl_mul_sel_t MUL_ENV_OLD = 3'd1;
  localparam spl_mul_sel_t MUL_ENV_NEW = 3'd2;
  localparam spl_mul_sel_t MUL_GAIN    = 3'd3;
  localparam spl_mul_sel_t MUL_LEFT    = 3'd4;
  localparam spl_mul_sel_t MUL_RIGHT   = 3'd5;

  // Configuration register file contents
  typedef struct packed {
    logic              limiter_enable;
    logic [1:0]        active_channels;
    logic [COEF_W-1:0] attack_coeff;
    logic [COEF_W-1:0] release_coeff;
    logic [GAIN_W-1:0] ceiling_level;
  } spl_cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic         load_in;
    logic         acc_load;
    logic         env_upd;
    logic         div_init;
    logic         div_step;
    logic         gain_upd;
    logic         res_left;
    logic         res_right;
    logic         out_load;
    spl_mul_sel_t mul_sel;
  } spl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bypass;
    logic no_div;
  } spl_sts_t;

endpackage

[src/spl_ctrl.sv]
// Sequencer of the stereo peak limiter: handshakes and datapath commands.
// Depends on spl_pkg.
module spl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  spl_pkg::spl_sts_t sts,
  output spl_pkg::spl_cmd_t cmd
);
  import spl_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ENV_A   = 4'd1;
  localparam logic [3:0] S_ENV_B   = 4'd2;
  localparam logic [3:0] S_ENV_C   = 4'd3;
  localparam logic [3:0] S_DIV_SET = 4'd4;
  localparam logic [3:0] S_DIV     = 4'd5;
  localparam logic [3:0] S_GAIN_M  = 4'd6;
  localparam logic [3:0] S_GAIN_U  = 4'd7;
  localparam logic [3:0] S_SCL_L   = 4'd8;
  localparam logic [3:0] S_SCL_R   = 4'd9;
  localparam logic [3:0] S_SCL_D   = 4'd10;
  localparam logic [3:0] S_OUT     = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state, step counter and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mul_sel   = MUL_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sts.bypass ? S_OUT : S_ENV_A;
        end
      end
      S_ENV_A: begin
        cmd.mul_sel = MUL_ENV_OLD;
        state_nxt   = S_ENV_B;
      end
      S_ENV_B: begin
        cmd.mul_sel  = MUL_ENV_NEW;
        cmd.acc_load = 1'b1;
        state_nxt    = S_ENV_C;
      end
      S_ENV_C: begin
        cmd.env_upd = 1'b1;
        state_nxt   = S_DIV_SET;
      end
      S_DIV_SET: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = CNT_W'(DIV_STEPS - 1);
        state_nxt    = sts.no_div ? S_GAIN_M : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_GAIN_M;
        end
      end
      S_GAIN_M: begin
        cmd.mul_sel = MUL_GAIN;
        state_nxt   = S_GAIN_U;
      end
      S_GAIN_U: begin
        cmd.gain_upd = 1'b1;
        state_nxt    = S_SCL_L;
      end
      S_SCL_L: begin
        cmd.mul_sel = MUL_LEFT;
        state_nxt   = S_SCL_R;
      end
      S_SCL_R: begin
        cmd.mul_sel  = MUL_RIGHT;
        cmd.res_left = 1'b1;
        state_nxt    = S_SCL_D;
      end
      S_SCL_D: begin
        cmd.res_right = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        // Hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/spl_dp.sv]
// Datapath of the stereo peak limiter: envelope, divider, gain and scaling.
// Depends on spl_pkg; driven by spl_ctrl commands.
module spl_dp #(
  parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  spl_pkg::spl_cfg_t               cfg,
  input  spl_pkg::spl_cmd_t               cmd,
  output spl_pkg::spl_sts_t               sts,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample_left,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample_right,
  output logic signed [SAMPLE_BITS-1:0]   out_left,
  output logic signed [SAMPLE_BITS-1:0]   out_right,
  output logic [spl_pkg::GAIN_W-1:0]      out_gain_applied,
  output logic                            out_limiting
);
  import spl_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int MA = (SB > GAIN_W) ? SB : GAIN_W;
  localparam int MB = COEF_W + 1;
  localparam int PW = MA + MB;
  localparam logic [PW-1:0] RND = PW'((64'd1 << COEF_W) - 64'd1);

  // Frame registers
  logic [SB-1:0]     mag_l_r, mag_r_r, peak_r;
  logic              neg_l_r, neg_r_r;
  logic [SB-1:0]     res_l_r, res_r_r;
  logic [GAIN_W-1:0] res_gain_r;

  // Limiter state
  logic [GAIN_W-1:0] env_r, gain_r;

  // Arithmetic registers
  logic [PW-1:0]     prod_r, acc_r;
  logic [MA-1:0]     rem_r, div_r;
  logic [GAIN_W-1:0] q_r;

  // Output register
  logic [SB-1:0]     out_l_r, out_r_r;
  logic [GAIN_W-1:0] out_gain_r;
  logic              out_lim_r;

  logic [SB-1:0]     mag_l, mag_r, peak_in, r_l, r_r;
  logic              chans2;
  logic [MA-1:0]     peak_x, env_x, ceil_x, divisor, mul_a;
  logic [MB-1:0]     mul_b;
  logic [COEF_W-1:0] coef;
  logic [MB-1:0]     coef_inv, rel_inv;
  logic              env_big, peak_big;
  logic [PW:0]       env_sum;
  logic [MA:0]       rem_sh, rem_sub;
  logic              q_bit;
  logic [PW-1:0]     rnd_sum;
  logic [GAIN_W-1:0] gain_diff, gain_nxt;

  // Magnitudes and peak of the incoming frame
  assign chans2  = cfg.active_channels[1];
  assign mag_l   = in_sample_left[SB-1] ? (~in_sample_left) + SB'(1) : in_sample_left;
  assign mag_r   = in_sample_right[SB-1] ? (~in_sample_right) + SB'(1) : in_sample_right;
  assign peak_in = (chans2 && (mag_r > mag_l)) ? mag_r : mag_l;

  // Coefficient choice and divisor selection
  assign peak_x   = MA'(peak_r);
  assign env_x    = MA'(env_r);
  assign ceil_x   = MA'(cfg.ceiling_level);
  assign coef     = (peak_x > env_x) ? cfg.attack_coeff : cfg.release_coeff;
  assign coef_inv = COEF_ONE - {1'b0, coef};
  assign rel_inv  = COEF_ONE - {1'b0, cfg.release_coeff};
  assign env_big  = env_x > ceil_x;
  assign peak_big = peak_x > ceil_x;

  always_comb begin
    if (env_big && (!peak_big || (env_x >= peak_x))) begin
      divisor = env_x;
    end else begin
      divisor = peak_x;
    end
  end

  assign sts.bypass = !cfg.limiter_enable || (cfg.active_channels == 2'd0);
  assign sts.no_div = !env_big && !peak_big;

  // Shared multiplier operands
  assign gain_diff = q_r - gain_r;

  always_comb begin
    case (cmd.mul_sel)
      MUL_ENV_OLD: begin
        mul_a = env_x;
        mul_b = MB'(coef);
      end
      MUL_ENV_NEW: begin
        mul_a = peak_x;
        mul_b = coef_inv;
      end
      MUL_GAIN: begin
        mul_a = MA'(gain_diff);
        mul_b = rel_inv;
      end
      MUL_LEFT: begin
        mul_a = MA'(mag_l_r);
        mul_b = MB'(gain_r);
      end
      MUL_RIGHT: begin
        mul_a = MA'(mag_r_r);
        mul_b = MB'(gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Envelope sum, divider step, gain recovery and scaled magnitudes
  assign env_sum = {1'b0, acc_r} + {1'b0, prod_r};
  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign q_bit   = rem_sh >= {1'b0, div_r};
  assign rnd_sum = prod_r + RND;

  always_comb begin
    if (q_r < gain_r) begin
      gain_nxt = q_r;
    end else begin
      gain_nxt = gain_r + rnd_sum[COEF_W +: GAIN_W];
    end
  end

  assign r_l = prod_r[GAIN_W-1 +: SB];
  assign r_r = prod_r[GAIN_W-1 +: SB];

  // Hold product and accumulator
  always_ff @(posedge clk) begin
    prod_r <= {{MB{1'b0}}, mul_a} * {{MA{1'b0}}, mul_b};
    if (cmd.acc_load) begin
      acc_r <= prod_r;
    end
  end

  // Latch the frame and preset the result for bypass
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mag_l_r    <= mag_l;
      mag_r_r    <= mag_r;
      neg_l_r    <= in_sample_left[SB-1];
      neg_r_r    <= in_sample_right[SB-1];
      peak_r     <= peak_in;
      res_l_r    <= in_sample_left;
      res_r_r    <= in_sample_right;
      res_gain_r <= GAIN_ONE;
    end
    if (cmd.gain_upd) begin
      res_gain_r <= gain_nxt;
    end
    if (cmd.res_left) begin
      res_l_r <= neg_l_r ? (~r_l) + SB'(1) : r_l;
    end
    if (cmd.res_right && chans2) begin
      res_r_r <= neg_r_r ? (~r_r) + SB'(1) : r_r;
    end
  end

  // Advance the restoring divider
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= ceil_x;
      div_r <= divisor;
      q_r   <= (!env_big && !peak_big) ? GAIN_ONE : '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_sub[MA-1:0] : rem_sh[MA-1:0];
      q_r   <= {q_r[GAIN_W-2:0], q_bit};
    end
  end

  // Envelope and gain state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r  <= '0;
      gain_r <= GAIN_ONE;
    end else if (cmd.load_in && !cfg.limiter_enable) begin
      env_r  <= '0;
      gain_r <= GAIN_ONE;
    end else begin
      if (cmd.env_upd) begin
        env_r <= env_sum[COEF_W +: GAIN_W];
      end
      if (cmd.gain_upd) begin
        gain_r <= gain_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_l_r    <= res_l_r;
      out_r_r    <= res_r_r;
      out_gain_r <= res_gain_r;
      out_lim_r  <= res_gain_r < GAIN_ONE;
    end
  end

  assign out_left         = out_l_r;
  assign out_right        = out_r_r;
  assign out_gain_applied = out_gain_r;
  assign out_limiting     = out_lim_r;

endmodule

[src/stereo_peak_limiter.sv]
// Top level of the stereo peak limiter: configuration registers and wiring.
// Depends on spl_pkg, spl_ctrl and spl_dp.
//
//   channel   ports                                                direction
//   in_       in_sample_left, in_sample_right                      request in
//   out_      out_left, out_right, out_gain_applied, out_limiting  request out
//   cfg_      cfg_index, cfg_data                                  register write
//
// A frame whose envelope or peak exceeds the ceiling passes through the
// one-bit-per-cycle restoring divider that forms ceiling / level; any
// other active frame skips it. A bypassed frame (limiter off or no channel
// active) goes straight from accept to the output register.
// Reset is synchronous and active low; it restores the register defaults,
// zero envelope and unity gain. A result held in the output register does
// not stop the next frame from entering; a frame waits for the output
// register only at its last step. Configuration writes are always taken.
module stereo_peak_limiter #(
  parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_left,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_right,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_left,
  output logic signed [SAMPLE_BITS-1:0]     out_right,
  output logic [spl_pkg::GAIN_W-1:0]        out_gain_applied,
  output logic                              out_limiting,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import spl_pkg::*;

  spl_cfg_t cfg_r;
  spl_cmd_t cmd;
  spl_sts_t sts;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limiter_enable  <= RST_ENABLE;
      cfg_r.active_channels <= RST_CHANNELS;
      cfg_r.attack_coeff    <= RST_ATTACK;
      cfg_r.release_coeff   <= RST_RELEASE;
      cfg_r.ceiling_level   <= RST_CEILING;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:   cfg_r.limiter_enable  <= cfg_data[0];
        REG_CHANNELS: cfg_r.active_channels <= cfg_data[1:0];
        REG_ATTACK:   cfg_r.attack_coeff    <= cfg_data[COEF_W-1:0];
        REG_RELEASE:  cfg_r.release_coeff   <= cfg_data[COEF_W-1:0];
        REG_CEILING:  cfg_r.ceiling_level   <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  spl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spl_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample_left   (in_sample_left),
    .in_sample_right  (in_sample_right),
    .out_left         (out_left),
    .out_right        (out_right),
    .out_gain_applied (out_gain_applied),
    .out_limiting     (out_limiting)
  );

endmodule

[src/spl_checker.sv]
// Port-level assertions for the stereo peak limiter, bound to the top level.
// Depends on spl_pkg and stereo_peak_limiter.
module spl_checker #(
  parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_BITS-1:0]  out_left,
  input logic signed [SAMPLE_BITS-1:0]  out_right,
  input logic [spl_pkg::GAIN_W-1:0]     out_gain_applied,
  input logic                           out_limiting
);
  import spl_pkg::*;

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) &&
      $stable(out_right) && $stable(out_gain_applied))
    else $error("stalled result changed");

  // Gain never exceeds unity
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gain_applied <= GAIN_ONE)
    else $error("gain above unity");

  // Limiting flag agrees with the gain
  a_lim_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_limiting == (out_gain_applied != GAIN_ONE))
    else $error("limiting flag disagrees with gain");

endmodule

bind stereo_peak_limiter spl_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_spl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_left         (out_left),
  .out_right        (out_right),
  .out_gain_applied (out_gain_applied),
  .out_limiting     (out_limiting)
);
